FILE: rtl/ttdg_pkg.sv
// Shared types, register map and constants for the touch tap and drag gesture detector.
package ttdg_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PosW    = 16;
  localparam int unsigned MsCfgW  = 16;
  localparam int unsigned OffW    = 15;
  localparam int unsigned OffSqW  = 2 * OffW;

  // Double tap window: 0.2 s
  localparam logic [TimeW:0] DblTapWindowMs = (TimeW + 1)'(200);

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] RegPressDelay = 3'd0;
  localparam logic [2:0] RegTapMinDur  = 3'd1;
  localparam logic [2:0] RegTapMaxDur  = 3'd2;
  localparam logic [2:0] RegTapMaxOff  = 3'd3;
  localparam logic [2:0] RegQuitXLow   = 3'd4;
  localparam logic [2:0] RegQuitYLow   = 3'd5;
  localparam logic [2:0] RegQuitXHigh  = 3'd6;
  localparam logic [2:0] RegQuitYHigh  = 3'd7;

  typedef struct packed {
    logic [MsCfgW-1:0]      press_delay;
    logic [MsCfgW-1:0]      tap_min_duration;
    logic [MsCfgW-1:0]      tap_max_duration;
    logic [OffW-1:0]        tap_max_offset;
    logic [OffSqW-1:0]      tap_max_offset_sq;
    logic signed [PosW-1:0] quit_x_low;
    logic signed [PosW-1:0] quit_y_low;
    logic signed [PosW-1:0] quit_x_high;
    logic signed [PosW-1:0] quit_y_high;
  } cfg_t;

  typedef struct packed {
    logic                   quit_ack;
    logic                   touched;
    logic [TimeW-1:0]       now_ms;
    logic [TimeW-1:0]       sample_ms;
    logic signed [PosW-1:0] sample_x;
    logic signed [PosW-1:0] sample_y;
  } item_t;

  typedef struct packed {
    logic                   is_pressing;
    logic                   press_pulse;
    logic                   release_pulse;
    logic                   is_dragging;
    logic                   double_tap;
    logic                   single_tap;
    logic                   quit_flag;
    logic signed [PosW-1:0] last_x;
    logic signed [PosW-1:0] last_y;
  } result_t;

endpackage

FILE: rtl/touch_tap_drag_gesture_detector_top.sv
// Top level of the touch tap, double tap and drag gesture detector.
//
// One transaction on the input channel is one frame update; each frame gives exactly one
// result transaction with the pressing, press/release pulse, dragging, single and double
// tap flags, the quit flag and the last touched position. The block takes one frame per
// clock cycle while the output is not stalled: a frame sits in the input register while
// the gesture logic computes the new state, then moves to the result register when that
// register is free or draining, where it raises out_valid_o. in_ready_o follows
// out_ready_i combinationally through the two stages. A double tap ending inside the
// quit box sets quit_flag and freezes the gesture state until a frame with quit_ack_i
// set. Configuration registers sit on the APB port at byte address 4 * index; the user
// must write them only while no frame is in flight, as the block does not enforce it.
module touch_tap_drag_gesture_detector_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttdg_pkg::AddrW-1:0]         paddr,
  input  logic [ttdg_pkg::DataW-1:0]         pwdata,
  output logic [ttdg_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               quit_ack_i,
  input  logic                               touched_i,
  input  logic [ttdg_pkg::TimeW-1:0]         now_ms_i,
  input  logic [ttdg_pkg::TimeW-1:0]         sample_ms_i,
  input  logic signed [ttdg_pkg::PosW-1:0]   sample_x_i,
  input  logic signed [ttdg_pkg::PosW-1:0]   sample_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_pressing_o,
  output logic                               press_pulse_o,
  output logic                               release_pulse_o,
  output logic                               is_dragging_o,
  output logic                               double_tap_o,
  output logic                               single_tap_o,
  output logic                               quit_flag_o,
  output logic signed [ttdg_pkg::PosW-1:0]   last_x_o,
  output logic signed [ttdg_pkg::PosW-1:0]   last_y_o
);
  import ttdg_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    advance;
  logic    in_take;

  ttdg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // move the held frame into the result register when that slot is free or draining
  assign advance    = item_valid_q & (~res_valid_q | out_ready_i);
  assign in_ready_o = ~item_valid_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  ttdg_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .advance_i (advance),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.quit_ack  <= quit_ack_i;
      item_q.touched   <= touched_i;
      item_q.now_ms    <= now_ms_i;
      item_q.sample_ms <= sample_ms_i;
      item_q.sample_x  <= sample_x_i;
      item_q.sample_y  <= sample_y_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign is_pressing_o   = res_q.is_pressing;
  assign press_pulse_o   = res_q.press_pulse;
  assign release_pulse_o = res_q.release_pulse;
  assign is_dragging_o   = res_q.is_dragging;
  assign double_tap_o    = res_q.double_tap;
  assign single_tap_o    = res_q.single_tap;
  assign quit_flag_o     = res_q.quit_flag;
  assign last_x_o        = res_q.last_x;
  assign last_y_o        = res_q.last_y;

endmodule

FILE: rtl/ttdg_cfg.sv
// APB configuration registers of the gesture detector.
module ttdg_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttdg_pkg::AddrW-1:0]  paddr,
  input  logic [ttdg_pkg::DataW-1:0]  pwdata,
  output logic [ttdg_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output ttdg_pkg::cfg_t              cfg_o
);
  import ttdg_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic            wr_en;
  logic [2:0]      reg_idx;
  logic [OffW-1:0] off_new;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign off_new = pwdata[OffW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPressDelay: cfg_d.press_delay      = pwdata[MsCfgW-1:0];
        RegTapMinDur:  cfg_d.tap_min_duration = pwdata[MsCfgW-1:0];
        RegTapMaxDur:  cfg_d.tap_max_duration = pwdata[MsCfgW-1:0];
        RegTapMaxOff: begin
          cfg_d.tap_max_offset    = off_new;
          // keep the squared limit ready for the distance compare
          cfg_d.tap_max_offset_sq = OffSqW'(off_new) * OffSqW'(off_new);
        end
        RegQuitXLow:   cfg_d.quit_x_low  = pwdata[PosW-1:0];
        RegQuitYLow:   cfg_d.quit_y_low  = pwdata[PosW-1:0];
        RegQuitXHigh:  cfg_d.quit_x_high = pwdata[PosW-1:0];
        RegQuitYHigh:  cfg_d.quit_y_high = pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_delay       <= MsCfgW'(50);
      cfg_q.tap_min_duration  <= MsCfgW'(30);
      cfg_q.tap_max_duration  <= MsCfgW'(150);
      cfg_q.tap_max_offset    <= OffW'(1638);
      cfg_q.tap_max_offset_sq <= OffSqW'(1638 * 1638);
      cfg_q.quit_x_low        <= PosW'(12288);
      cfg_q.quit_y_low        <= PosW'(12288);
      cfg_q.quit_x_high       <= PosW'(16384);
      cfg_q.quit_y_high       <= PosW'(16384);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPressDelay: prdata = DataW'(cfg_q.press_delay);
      RegTapMinDur:  prdata = DataW'(cfg_q.tap_min_duration);
      RegTapMaxDur:  prdata = DataW'(cfg_q.tap_max_duration);
      RegTapMaxOff:  prdata = DataW'(cfg_q.tap_max_offset);
      RegQuitXLow:   prdata = DataW'(cfg_q.quit_x_low);
      RegQuitYLow:   prdata = DataW'(cfg_q.quit_y_low);
      RegQuitXHigh:  prdata = DataW'(cfg_q.quit_x_high);
      RegQuitYHigh:  prdata = DataW'(cfg_q.quit_y_high);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ttdg_core.sv
// Gesture state and the per-frame next-state logic.
module ttdg_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttdg_pkg::cfg_t    cfg_i,
  input  ttdg_pkg::item_t   item_i,
  input  logic              advance_i,
  output ttdg_pkg::result_t res_o
);
  import ttdg_pkg::*;

  logic                   holding_q, holding_d;
  logic                   press_evt_q, press_evt_d;
  logic                   release_evt_q, release_evt_d;
  logic                   drag_on_q, drag_on_d;
  logic                   dbl_evt_q, dbl_evt_d;
  logic                   tap_evt_q, tap_evt_d;
  logic                   quit_latch_q, quit_latch_d;
  logic [TimeW-1:0]       begin_time_q, begin_time_d;
  logic [TimeW-1:0]       finish_time_q, finish_time_d;
  logic signed [PosW-1:0] begin_x_q, begin_x_d, begin_y_q, begin_y_d;
  logic signed [PosW-1:0] finish_x_q, finish_x_d, finish_y_q, finish_y_d;
  logic                   tap_slot_q, tap_slot_d;
  logic [TimeW-1:0]       tap_beg_q [2];
  logic [TimeW-1:0]       tap_beg_d [2];
  logic [TimeW-1:0]       tap_fin_q [2];
  logic [TimeW-1:0]       tap_fin_d [2];

  logic                   slot_sel;
  logic                   drag_hit, win_miss, rel_hit, tap_close, in_box;
  logic signed [PosW:0]   dx, dy;
  logic [2*PosW+1:0]      dx_sq, dy_sq;
  logic [2*PosW+2:0]      dist_sq;
  logic                   dist_ok;
  logic [TimeW:0]         dur;
  logic                   dur_ok;
  logic                   tap_ok;

  // all time sums and compares carry one extra bit so they never wrap
  assign drag_hit = {1'b0, item_i.sample_ms} >
                    ({1'b0, begin_time_q} + (TimeW + 1)'(cfg_i.press_delay));
  assign win_miss = {1'b0, item_i.sample_ms} > ({1'b0, tap_fin_q[0]} + DblTapWindowMs);
  assign rel_hit  = ({1'b0, finish_time_q} + (TimeW + 1)'(cfg_i.press_delay)) <
                    {1'b0, item_i.now_ms};
  assign tap_close = {1'b0, finish_time_q} < ({1'b0, tap_beg_q[tap_slot_q]} + DblTapWindowMs);

  assign in_box = (finish_x_q >= $signed(cfg_i.quit_x_low)) &&
                  (finish_x_q <= $signed(cfg_i.quit_x_high)) &&
                  (finish_y_q >= $signed(cfg_i.quit_y_low)) &&
                  (finish_y_q <= $signed(cfg_i.quit_y_high));

  // single tap works on stored positions and times: they hold still on a release frame
  assign dx      = (PosW + 1)'(finish_x_q) - (PosW + 1)'(begin_x_q);
  assign dy      = (PosW + 1)'(finish_y_q) - (PosW + 1)'(begin_y_q);
  assign dx_sq   = (2 * PosW + 2)'(dx * dx);
  assign dy_sq   = (2 * PosW + 2)'(dy * dy);
  assign dist_sq = (2 * PosW + 3)'(dx_sq) + (2 * PosW + 3)'(dy_sq);
  assign dist_ok = dist_sq < (2 * PosW + 3)'(cfg_i.tap_max_offset_sq);

  assign dur    = {1'b0, finish_time_q} - {1'b0, begin_time_q};
  assign dur_ok = (finish_time_q >= begin_time_q) &&
                  (dur[TimeW-1:0] > TimeW'(cfg_i.tap_min_duration)) &&
                  (dur[TimeW-1:0] < TimeW'(cfg_i.tap_max_duration));
  assign tap_ok = dist_ok & dur_ok;

  always_comb begin
    holding_d     = holding_q;
    press_evt_d   = press_evt_q;
    release_evt_d = release_evt_q;
    drag_on_d     = drag_on_q;
    dbl_evt_d     = dbl_evt_q;
    tap_evt_d     = tap_evt_q;
    begin_time_d  = begin_time_q;
    finish_time_d = finish_time_q;
    begin_x_d     = begin_x_q;
    begin_y_d     = begin_y_q;
    finish_x_d    = finish_x_q;
    finish_y_d    = finish_y_q;
    tap_slot_d    = tap_slot_q;
    tap_beg_d     = tap_beg_q;
    tap_fin_d     = tap_fin_q;
    slot_sel      = tap_slot_q;
    // acknowledge clears the latch before the frame is handled
    quit_latch_d  = quit_latch_q & ~item_i.quit_ack;

    if (!quit_latch_d) begin
      press_evt_d   = 1'b0;
      release_evt_d = 1'b0;
      dbl_evt_d     = 1'b0;
      if (item_i.touched) begin
        finish_time_d = item_i.sample_ms;
        finish_x_d    = item_i.sample_x;
        finish_y_d    = item_i.sample_y;
        if (!holding_q) begin
          holding_d    = 1'b1;
          press_evt_d  = 1'b1;
          drag_on_d    = 1'b0;
          begin_time_d = item_i.sample_ms;
          begin_x_d    = item_i.sample_x;
          begin_y_d    = item_i.sample_y;
          // drop a pending first tap once the window has passed
          if (tap_slot_q && win_miss) begin
            slot_sel = 1'b0;
          end
          tap_slot_d          = slot_sel;
          tap_beg_d[slot_sel] = item_i.sample_ms;
        end else if (drag_hit) begin
          drag_on_d = 1'b1;
        end
      end else if (holding_q && rel_hit) begin
        holding_d             = 1'b0;
        release_evt_d         = 1'b1;
        drag_on_d             = 1'b0;
        tap_fin_d[tap_slot_q] = finish_time_q;
        if (tap_close && !tap_slot_q) begin
          tap_slot_d = 1'b1;
        end else if (tap_close) begin
          dbl_evt_d    = 1'b1;
          quit_latch_d = in_box;
          tap_slot_d   = 1'b0;
        end else begin
          tap_slot_d = 1'b0;
        end
      end
      tap_evt_d = release_evt_d & tap_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q     <= 1'b0;
      press_evt_q   <= 1'b0;
      release_evt_q <= 1'b0;
      drag_on_q     <= 1'b0;
      dbl_evt_q     <= 1'b0;
      tap_evt_q     <= 1'b0;
      quit_latch_q  <= 1'b0;
      begin_time_q  <= '0;
      finish_time_q <= '0;
      begin_x_q     <= '0;
      begin_y_q     <= '0;
      finish_x_q    <= '0;
      finish_y_q    <= '0;
      tap_slot_q    <= 1'b0;
      tap_beg_q     <= '{default: '0};
      tap_fin_q     <= '{default: '0};
    end else if (advance_i) begin
      holding_q     <= holding_d;
      press_evt_q   <= press_evt_d;
      release_evt_q <= release_evt_d;
      drag_on_q     <= drag_on_d;
      dbl_evt_q     <= dbl_evt_d;
      tap_evt_q     <= tap_evt_d;
      quit_latch_q  <= quit_latch_d;
      begin_time_q  <= begin_time_d;
      finish_time_q <= finish_time_d;
      begin_x_q     <= begin_x_d;
      begin_y_q     <= begin_y_d;
      finish_x_q    <= finish_x_d;
      finish_y_q    <= finish_y_d;
      tap_slot_q    <= tap_slot_d;
      tap_beg_q     <= tap_beg_d;
      tap_fin_q     <= tap_fin_d;
    end
  end

  always_comb begin
    res_o.is_pressing   = holding_d;
    res_o.press_pulse   = press_evt_d;
    res_o.release_pulse = release_evt_d;
    res_o.is_dragging   = drag_on_d;
    res_o.double_tap    = dbl_evt_d;
    res_o.single_tap    = tap_evt_d;
    res_o.quit_flag     = quit_latch_d;
    res_o.last_x        = finish_x_d;
    res_o.last_y        = finish_y_d;
  end

endmodule

FILE: tb/touch_tap_drag_gesture_detector_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed and random touch frames checked against a local gesture model.
module touch_tap_drag_gesture_detector_top_tb;
  import ttdg_pkg::*;

  localparam int unsigned TimeoutNs  = 400_000;
  localparam int unsigned MaxShown   = 10;
  localparam int unsigned PhaseItems = 170;
  localparam int          PosMin     = -16384;
  localparam int          PosMax     = 16384;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [AddrW-1:0]       paddr;
  logic [DataW-1:0]       pwdata;
  logic [DataW-1:0]       prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   quit_ack_i;
  logic                   touched_i;
  logic [TimeW-1:0]       now_ms_i;
  logic [TimeW-1:0]       sample_ms_i;
  logic signed [PosW-1:0] sample_x_i;
  logic signed [PosW-1:0] sample_y_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   is_pressing_o;
  logic                   press_pulse_o;
  logic                   release_pulse_o;
  logic                   is_dragging_o;
  logic                   double_tap_o;
  logic                   single_tap_o;
  logic                   quit_flag_o;
  logic signed [PosW-1:0] last_x_o;
  logic signed [PosW-1:0] last_y_o;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned n_sent;
  int unsigned n_fail;
  logic [TimeW-1:0] frame_clock_ms;
  result_t frame_results_q[$];

  // Settings as the detector should hold them
  logic [MsCfgW-1:0]      cfg_press_delay = 16'd50;
  logic [MsCfgW-1:0]      cfg_tap_min     = 16'd30;
  logic [MsCfgW-1:0]      cfg_tap_max     = 16'd150;
  logic [OffW-1:0]        cfg_tap_off     = 15'd1638;
  logic signed [PosW-1:0] cfg_qx_lo       = 16'sd12288;
  logic signed [PosW-1:0] cfg_qy_lo       = 16'sd12288;
  logic signed [PosW-1:0] cfg_qx_hi       = 16'sd16384;
  logic signed [PosW-1:0] cfg_qy_hi       = 16'sd16384;

  // Gesture tracking state
  logic                   st_holding  = 1'b0;
  logic                   st_press    = 1'b0;
  logic                   st_release  = 1'b0;
  logic                   st_drag     = 1'b0;
  logic                   st_dbl      = 1'b0;
  logic                   st_tap      = 1'b0;
  logic                   st_quit     = 1'b0;
  logic [TimeW-1:0]       st_t_begin  = '0;
  logic [TimeW-1:0]       st_t_finish = '0;
  logic signed [PosW-1:0] st_begin_x  = '0;
  logic signed [PosW-1:0] st_begin_y  = '0;
  logic signed [PosW-1:0] st_finish_x = '0;
  logic signed [PosW-1:0] st_finish_y = '0;
  logic                   st_slot     = 1'b0;
  logic [TimeW-1:0]       st_tap_t_begin [2] = '{32'd0, 32'd0};
  logic [TimeW-1:0]       st_tap_t_finish[2] = '{32'd0, 32'd0};

  touch_tap_drag_gesture_detector_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .quit_ack_i      (quit_ack_i),
    .touched_i       (touched_i),
    .now_ms_i        (now_ms_i),
    .sample_ms_i     (sample_ms_i),
    .sample_x_i      (sample_x_i),
    .sample_y_i      (sample_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_pressing_o   (is_pressing_o),
    .press_pulse_o   (press_pulse_o),
    .release_pulse_o (release_pulse_o),
    .is_dragging_o   (is_dragging_o),
    .double_tap_o    (double_tap_o),
    .single_tap_o    (single_tap_o),
    .quit_flag_o     (quit_flag_o),
    .last_x_o        (last_x_o),
    .last_y_o        (last_y_o)
  );

  always #1 clk_i = ~clk_i;

  // Advance the gesture state by one frame and return the flags it reports.
  function automatic result_t track_gesture(input item_t f);
    result_t r;
    longint  dx;
    longint  dy;
    longint  dur;
    longint  lim;
    longint  t_fin;
    longint  t_beg;
    logic    s;
    if (f.quit_ack) st_quit = 1'b0;
    if (!st_quit) begin
      if (f.touched) begin
        st_t_finish = f.sample_ms;
        st_finish_x = f.sample_x;
        st_finish_y = f.sample_y;
      end
      st_release = 1'b0;
      st_press   = 1'b0;
      st_dbl     = 1'b0;
      if (f.touched) begin
        if (!st_holding) begin
          st_holding = 1'b1;
          st_press   = 1'b1;
          st_drag    = 1'b0;
          st_t_begin = f.sample_ms;
          st_begin_x = f.sample_x;
          st_begin_y = f.sample_y;
          // Second press too late after the first release: start a fresh tap pair
          if (st_slot && ({32'd0, st_t_begin} >
                          {32'd0, st_tap_t_finish[0]} + {31'd0, DblTapWindowMs}))
            st_slot = 1'b0;
          st_tap_t_begin[st_slot] = st_t_begin;
        end else if ({32'd0, st_t_finish} > {32'd0, st_t_begin} + {48'd0, cfg_press_delay}) begin
          st_drag = 1'b1;
        end
      end else if (st_holding) begin
        if ({32'd0, st_t_finish} + {48'd0, cfg_press_delay} < {32'd0, f.now_ms}) begin
          s = st_slot;
          st_holding = 1'b0;
          st_release = 1'b1;
          st_drag    = 1'b0;
          st_tap_t_finish[s] = st_t_finish;
          if ({32'd0, st_tap_t_finish[s]} <
              {32'd0, st_tap_t_begin[s]} + {31'd0, DblTapWindowMs}) begin
            if (!s) begin
              st_slot = 1'b1;
            end else begin
              st_dbl  = 1'b1;
              st_quit = st_finish_x >= cfg_qx_lo && st_finish_x <= cfg_qx_hi &&
                        st_finish_y >= cfg_qy_lo && st_finish_y <= cfg_qy_hi;
              st_slot = 1'b0;
            end
          end else begin
            st_slot = 1'b0;
          end
        end
      end
      st_tap = 1'b0;
      if (st_release) begin
        dx    = longint'(st_finish_x) - longint'(st_begin_x);
        dy    = longint'(st_finish_y) - longint'(st_begin_y);
        lim   = cfg_tap_off;
        lim   = lim * lim;
        t_fin = st_t_finish;
        t_beg = st_t_begin;
        dur   = t_fin - t_beg;
        st_tap = (dx * dx + dy * dy) < lim && dur > longint'(cfg_tap_min) &&
                 dur < longint'(cfg_tap_max);
      end
    end
    r.is_pressing   = st_holding;
    r.press_pulse   = st_press;
    r.release_pulse = st_release;
    r.is_dragging   = st_drag;
    r.double_tap    = st_dbl;
    r.single_tap    = st_tap;
    r.quit_flag     = st_quit;
    r.last_x        = st_finish_x;
    r.last_y        = st_finish_y;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf("hold=%b press=%b rel=%b drag=%b dbl=%b tap=%b quit=%b x=%0d y=%0d",
                     r.is_pressing, r.press_pulse, r.release_pulse, r.is_dragging,
                     r.double_tap, r.single_tap, r.quit_flag, r.last_x, r.last_y);
  endfunction

  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [PosW-1:0] clamp_pos(input int v);
    if (v < PosMin) return PosW'(PosMin);
    if (v > PosMax) return PosW'(PosMax);
    return PosW'(v);
  endfunction

  // Ack often while quit is latched, rarely otherwise.
  function automatic logic next_ack();
    return st_quit ? ($urandom_range(2) == 0) : ($urandom_range(24) == 0);
  endfunction

  // Hold times near the tap and drag thresholds, plus some free ones.
  function automatic int pick_hold();
    case ($urandom_range(4))
      0: return $urandom_range(60);
      1: return int'(cfg_tap_min) + pick(-1, 1);
      2: return int'(cfg_tap_max) + pick(-1, 1);
      3: return int'(cfg_press_delay) + pick(-1, 2);
      default: return $urandom_range(400);
    endcase
  endfunction

  // Result side: stall at random, sample at the rising edge.
  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.is_pressing   = is_pressing_o;
      got.press_pulse   = press_pulse_o;
      got.release_pulse = release_pulse_o;
      got.is_dragging   = is_dragging_o;
      got.double_tap    = double_tap_o;
      got.single_tap    = single_tap_o;
      got.quit_flag     = quit_flag_o;
      got.last_x        = last_x_o;
      got.last_y        = last_y_o;
      if (frame_results_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxShown)
          $display("%0t: unexpected result: %s", $realtime, show_result(got));
      end else begin
        want = frame_results_q.pop_front();
        if (got.is_pressing !== want.is_pressing || got.press_pulse !== want.press_pulse ||
            got.release_pulse !== want.release_pulse ||
            got.is_dragging !== want.is_dragging || got.double_tap !== want.double_tap ||
            got.single_tap !== want.single_tap || got.quit_flag !== want.quit_flag ||
            got.last_x !== want.last_x || got.last_y !== want.last_y) begin
          n_fail++;
          if (n_fail <= MaxShown)
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                     show_result(want), show_result(got));
        end
      end
    end
  end

  // Send one frame; called and returning at a falling edge.
  task automatic send_frame(input logic ack, input logic touch, input logic [TimeW-1:0] now_v,
                            input logic [TimeW-1:0] smp_v, input logic signed [PosW-1:0] x,
                            input logic signed [PosW-1:0] y);
    item_t f;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    f.quit_ack  = ack;
    f.touched   = touch;
    f.now_ms    = now_v;
    f.sample_ms = smp_v;
    f.sample_x  = x;
    f.sample_y  = y;
    in_valid_i  = 1'b1;
    quit_ack_i  = ack;
    touched_i   = touch;
    now_ms_i    = now_v;
    sample_ms_i = smp_v;
    sample_x_i  = x;
    sample_y_i  = y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frame_results_q.push_back(track_gesture(f));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegPressDelay: cfg_press_delay = value[MsCfgW-1:0];
      RegTapMinDur:  cfg_tap_min     = value[MsCfgW-1:0];
      RegTapMaxDur:  cfg_tap_max     = value[MsCfgW-1:0];
      RegTapMaxOff:  cfg_tap_off     = value[OffW-1:0];
      RegQuitXLow:   cfg_qx_lo       = value[PosW-1:0];
      RegQuitYLow:   cfg_qy_lo       = value[PosW-1:0];
      RegQuitXHigh:  cfg_qx_hi       = value[PosW-1:0];
      RegQuitYHigh:  cfg_qy_hi       = value[PosW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_settings(input int unsigned pd, input int unsigned tmin,
                                input int unsigned tmax, input int unsigned off,
                                input int xl, input int yl, input int xh, input int yh);
    wait_drained();
    reg_write(RegPressDelay, pd);
    reg_write(RegTapMinDur, tmin);
    reg_write(RegTapMaxDur, tmax);
    reg_write(RegTapMaxOff, off);
    reg_write(RegQuitXLow, xl);
    reg_write(RegQuitYLow, yl);
    reg_write(RegQuitXHigh, xh);
    reg_write(RegQuitYHigh, yh);
  endtask

  task automatic write_random_settings();
    int xl;
    int yl;
    xl = pick(PosMin, 12000);
    yl = pick(PosMin, 12000);
    write_settings($urandom_range(150), $urandom_range(60), $urandom_range(60, 250),
                   $urandom_range(100, 4000), xl, yl, xl + pick(0, 8000), yl + pick(0, 8000));
  endtask

  // Touched frames from start to end position, spread over the hold time.
  task automatic send_touch(input int hold, input int x0, input int y0, input int x1,
                            input int y1, input int nframes);
    longint t;
    int     k;
    int     span;
    span = (nframes > 1) ? nframes - 1 : 1;
    if (hold < 0) hold = 0;
    t = frame_clock_ms;
    for (k = 0; k < nframes; k++) begin
      t = longint'(frame_clock_ms) + ((nframes > 1) ? longint'(hold) * k / span : 0);
      send_frame(next_ack(), 1'b1, t[31:0] + $urandom_range(2), t[31:0],
                 clamp_pos(x0 + (x1 - x0) * k / span), clamp_pos(y0 + (y1 - y0) * k / span));
    end
    frame_clock_ms = t[31:0];
  endtask

  // Untouched frames: up to two inside the release delay, then one past it.
  task automatic send_release();
    longint due;
    longint rel;
    due = st_t_finish;
    due = due + cfg_press_delay;
    repeat ($urandom_range(2)) begin
      rel = due - ($urandom_range(1) ? 0 : $urandom_range(cfg_press_delay));
      if (rel > 64'hFFFF_FFFF) rel = 64'hFFFF_FFFF;
      send_frame(next_ack(), 1'b0, rel[31:0], $urandom, 16'($urandom), 16'($urandom));
    end
    rel = due + 1 + $urandom_range(30);
    if (rel > 64'hFFFF_FFFF) rel = 64'hFFFF_FFFF;
    send_frame(next_ack(), 1'b0, rel[31:0], $urandom, 16'($urandom), 16'($urandom));
    frame_clock_ms = rel[31:0];
  endtask

  task automatic send_gesture(input int hold, input logic near_box);
    int x0;
    int y0;
    int dx;
    int dy;
    int lo;
    int hi;
    lo = (cfg_qx_lo > PosMin) ? cfg_qx_lo : PosMin;
    hi = (cfg_qx_hi < PosMax) ? cfg_qx_hi : PosMax;
    x0 = (near_box && lo <= hi) ? pick(lo, hi) : pick(PosMin, PosMax);
    lo = (cfg_qy_lo > PosMin) ? cfg_qy_lo : PosMin;
    hi = (cfg_qy_hi < PosMax) ? cfg_qy_hi : PosMax;
    y0 = (near_box && lo <= hi) ? pick(lo, hi) : pick(PosMin, PosMax);
    case ($urandom_range(3))
      0: begin dx = cfg_tap_off;     dy = 0; end
      1: begin dx = cfg_tap_off - 1; dy = 0; end
      2: begin
        dx = pick(-int'(cfg_tap_off) / 2, int'(cfg_tap_off) / 2);
        dy = pick(-int'(cfg_tap_off) / 2, int'(cfg_tap_off) / 2);
      end
      default: begin dx = pick(-8000, 8000); dy = pick(-8000, 8000); end
    endcase
    if ($urandom_range(1)) begin
      dx = -dx;
      dy = -dy;
    end
    if ($urandom_range(1)) begin
      lo = dx;
      dx = dy;
      dy = lo;
    end
    send_touch(hold, x0, y0, clamp_pos(x0 + dx), clamp_pos(y0 + dy), $urandom_range(1, 6));
    send_release();
  endtask

  task automatic test_tap_and_drag();
    send_frame(1'b0, 1'b0, 32'd0, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b0, 1'b1, 32'd100, 32'd100, -16'sd16384, -16'sd16384);
    send_frame(1'b0, 1'b1, 32'd120, 32'd120, -16'sd16334, -16'sd16384);
    // exactly at the press delay: no drag yet
    send_frame(1'b0, 1'b1, 32'd150, 32'd150, -16'sd16300, -16'sd16350);
    send_frame(1'b0, 1'b1, 32'd200, 32'd200, -16'sd16284, -16'sd16384);
    // silence equal to the press delay does not release
    send_frame(1'b0, 1'b0, 32'd250, 32'd7, 16'sd16384, 16'sd16384);
    send_frame(1'b0, 1'b0, 32'd251, 32'd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_time_and_range_edges();
    send_frame(1'b0, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'sh7FFF, 16'sh8000);
    // release point lies past the 32-bit range: no release
    send_frame(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd0, 16'sd0);
    // sample time before the start time
    send_frame(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd5, 16'sh8000, 16'sh7FFF);
    send_frame(1'b0, 1'b0, 32'd100, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b1, 1'b1, 32'd300, 32'd300, 16'sd16384, -16'sd16384);
    send_frame(1'b0, 1'b0, 32'd400, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_double_tap_quit();
    send_frame(1'b0, 1'b1, 32'd1000, 32'd1000, 16'sd14000, 16'sd14000);
    send_frame(1'b0, 1'b1, 32'd1040, 32'd1040, 16'sd14010, 16'sd14005);
    send_frame(1'b0, 1'b0, 32'd1100, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b0, 1'b1, 32'd1150, 32'd1150, 16'sd14020, 16'sd14020);
    // second tap ends inside the quit box
    send_frame(1'b0, 1'b0, 32'd1250, 32'd0, 16'sd0, 16'sd0);
    // frozen until acknowledged
    send_frame(1'b0, 1'b1, 32'd1260, 32'd1260, 16'sd0, 16'sd0);
    send_frame(1'b0, 1'b0, 32'd1300, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b1, 1'b1, 32'd1310, 32'd1310, -16'sd8000, 16'sd5000);
    send_frame(1'b0, 1'b0, 32'd1400, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b0, 1'b1, 32'd1450, 32'd1450, -16'sd8000, 16'sd5000);
    // double tap outside the box
    send_frame(1'b0, 1'b0, 32'd1600, 32'd0, 16'sd0, 16'sd0);
    send_frame(1'b1, 1'b0, 32'd1700, 32'd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_gestures(input int unsigned tx_idle, input int unsigned rx_stall,
                                      input int unsigned n_items);
    int unsigned stop_at;
    logic        near_box;
    tx_idle_pct    = tx_idle;
    rx_stall_pct   = rx_stall;
    stop_at        = n_sent + n_items;
    frame_clock_ms = $urandom_range(1000);
    while (n_sent < stop_at) begin
      near_box = ($urandom_range(2) == 0);
      case ($urandom_range(15))
        0: begin
          repeat ($urandom_range(1, 3))
            send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
                       16'($urandom), 16'($urandom));
        end
        1: begin
          // hold off until every result is back
          wait_drained();
          if ($urandom_range(3) == 0) frame_clock_ms = $urandom;
        end
        2, 3, 4: begin
          send_gesture($urandom_range(199), near_box);
          frame_clock_ms = frame_clock_ms + $urandom_range(40);
          send_gesture($urandom_range(199), near_box);
          frame_clock_ms = frame_clock_ms + $urandom_range(300);
        end
        default: begin
          send_gesture(pick_hold(), near_box);
          frame_clock_ms = frame_clock_ms + $urandom_range(300);
        end
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    quit_ack_i     = 1'b0;
    touched_i      = 1'b0;
    now_ms_i       = '0;
    sample_ms_i    = '0;
    sample_x_i     = '0;
    sample_y_i     = '0;
    out_ready_i    = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    n_sent         = 0;
    n_fail         = 0;
    frame_clock_ms = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_tap_and_drag();
    test_time_and_range_edges();
    test_double_tap_quit();

    test_random_gestures(37, 86, PhaseItems);
    write_settings(0, 0, 0, 0, -32768, -32768, 32767, 32767);
    test_random_gestures(37, 86, PhaseItems);
    write_random_settings();
    test_random_gestures(86, 37, PhaseItems);
    write_settings(65535, 65535, 65535, 32767, 32767, 32767, -32768, -32768);
    test_random_gestures(86, 37, PhaseItems);
    write_random_settings();
    test_random_gestures(0, 0, PhaseItems);
    write_random_settings();
    test_random_gestures(0, 0, PhaseItems);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_fail == 0 && frame_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ttdg_pkg.sv
rtl/ttdg_cfg.sv
rtl/ttdg_core.sv
rtl/touch_tap_drag_gesture_detector_top.sv
tb/touch_tap_drag_gesture_detector_top_tb.sv
